>>> sv/bms_pkg.sv
// Shared types and constants of the merge sorter.
`timescale 1ns / 1ps

package bms_pkg;

    // Width of one stored element.
    localparam int VALUE_W = 32;

    // Default number of elements that one set may hold.
    localparam int DEFAULT_CAPACITY = 64;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_START,
        ST_PASS_SETUP,
        ST_MERGE,
        ST_EMIT
    } state_t;

    // Memory controls from the sequencer.
    typedef struct packed {
        logic wr_a;   // write the element memory
        logic wr_b;   // write the scratch memory
        logic rd_en;  // update the read registers of both memories
        logic src_b;  // the scratch memory holds the current source data
    } ram_ctl_t;

endpackage

>>> sv/bms_ram.sv
// Storage array with one write port and two registered read ports.
`timescale 1ns / 1ps

module bms_ram
    import bms_pkg::*;
#(
    parameter int DEPTH = DEFAULT_CAPACITY
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [$clog2(DEPTH)-1:0]   waddr,
    input  logic [VALUE_W-1:0]         wdata,
    input  logic                       rd_en,
    input  logic [$clog2(DEPTH)-1:0]   raddr0,
    input  logic [$clog2(DEPTH)-1:0]   raddr1,
    output logic [VALUE_W-1:0]         rdata0,
    output logic [VALUE_W-1:0]         rdata1
);

    logic [VALUE_W-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read ports; the data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata0 <= mem[raddr0];
            rdata1 <= mem[raddr1];
        end
    end

endmodule

>>> sv/bms_ctrl.sv
// Sequencer of the sorter: loading, merge passes and emission.
`timescale 1ns / 1ps

module bms_ctrl
    import bms_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Input items
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [VALUE_W-1:0]            s_value,
    input  logic                          s_last,
    // Configuration
    input  logic                          cfg_wr_en,
    input  logic                          cfg_wr_data,
    // Heads of the two runs from the source memory
    input  logic [VALUE_W-1:0]            head_a,
    input  logic [VALUE_W-1:0]            head_b,
    // Result item control
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output logic                          m_tlast,
    output logic                          m_tuser,
    // Memory access
    output ram_ctl_t                      ram_ctl,
    output logic [$clog2(CAPACITY)-1:0]   waddr,
    output logic [VALUE_W-1:0]            wdata,
    output logic [$clog2(CAPACITY)-1:0]   raddr0,
    output logic [$clog2(CAPACITY)-1:0]   raddr1
);

    localparam int AW = $clog2(CAPACITY);
    // One bit above the address so the run width can reach the next power of two.
    localparam int CW = $clog2(CAPACITY) + 1;
    localparam int EW = CW + 2;

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            dropped_reg, dropped_next;
    logic            ascending_reg, ascending_next;
    logic [CW-1:0]   width_reg, width_next;
    logic [CW-1:0]   lo_reg, lo_next;
    logic [CW-1:0]   a_reg, a_next;       // left run pointer, emit index
    logic [CW-1:0]   b_reg, b_next;       // right run pointer
    logic [CW-1:0]   pos_reg, pos_next;   // write index, results left to emit
    logic            src_b_reg, src_b_next;
    logic            out_valid_reg, out_valid_next;
    logic            out_last_reg, out_last_next;
    logic            out_ovf_reg, out_ovf_next;

    logic [EW-1:0]   lo_e, w_e, n_e, a_e, b_e, pos_inc_e;
    logic [EW-1:0]   sum_mid, sum_hi, sum_nb;
    logic [EW-1:0]   mid_e, hi_e, nb_e;
    logic [CW-1:0]   pos_inc;
    logic            a_ok, b_ok, take_a, pair_done, pass_done;
    logic            load_acc, issue, sort_done;

    // Run bounds of the pair being merged, clamped to the set size.
    always_comb
    begin
        lo_e      = EW'(lo_reg);
        w_e       = EW'(width_reg);
        n_e       = EW'(count_reg);
        a_e       = EW'(a_reg);
        b_e       = EW'(b_reg);
        pos_inc   = pos_reg + CW'(1);
        pos_inc_e = EW'(pos_inc);
        sum_mid   = lo_e + w_e;
        sum_hi    = lo_e + (w_e << 1);
        mid_e     = (sum_mid < n_e) ? sum_mid : n_e;
        hi_e      = (sum_hi < n_e) ? sum_hi : n_e;
        sum_nb    = hi_e + w_e;
        nb_e      = (sum_nb < n_e) ? sum_nb : n_e;
        a_ok      = a_e < mid_e;
        b_ok      = b_e < hi_e;
        take_a    = a_ok && (!b_ok || !($signed(head_b) < $signed(head_a)));
        pair_done = pos_inc_e == hi_e;
        pass_done = hi_e == n_e;
        sort_done = w_e >= n_e;
    end

    assign s_tready = (state_reg == ST_LOAD);
    assign load_acc = s_tvalid && s_tready;
    assign issue    = (state_reg == ST_EMIT) && (!out_valid_reg || m_tready);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (load_acc && s_last)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                if (!out_valid_reg)
                begin
                    state_next = ST_PASS_SETUP;
                end
            end
            ST_PASS_SETUP:
            begin
                state_next = sort_done ? ST_EMIT : ST_MERGE;
            end
            ST_MERGE:
            begin
                if (pair_done && pass_done)
                begin
                    state_next = ST_PASS_SETUP;
                end
            end
            ST_EMIT:
            begin
                if (issue && (pos_reg == CW'(1)))
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Datapath controls and register updates per state.
    always_comb
    begin
        count_next     = count_reg;
        dropped_next   = dropped_reg;
        ascending_next = cfg_wr_en ? cfg_wr_data : ascending_reg;
        width_next     = width_reg;
        lo_next        = lo_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        pos_next       = pos_reg;
        src_b_next     = src_b_reg;
        out_last_next  = out_last_reg;
        out_ovf_next   = out_ovf_reg;
        out_valid_next = (out_valid_reg && m_tready) ? 1'b0 : out_valid_reg;
        ram_ctl.wr_a   = 1'b0;
        ram_ctl.wr_b   = 1'b0;
        ram_ctl.rd_en  = 1'b0;
        ram_ctl.src_b  = src_b_reg;
        waddr          = pos_reg[AW-1:0];
        wdata          = take_a ? head_a : head_b;
        unique case (state_reg)
            ST_LOAD:
            begin
                waddr = count_reg[AW-1:0];
                wdata = s_value;
                if (load_acc)
                begin
                    if (count_reg < CW'(CAPACITY))
                    begin
                        ram_ctl.wr_a = 1'b1;
                        count_next   = count_reg + CW'(1);
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                end
            end
            ST_START:
            begin
                // The previous set's final result may still sit in the read register.
                if (!out_valid_reg)
                begin
                    width_next = CW'(1);
                    src_b_next = 1'b0;
                end
            end
            ST_PASS_SETUP:
            begin
                if (sort_done)
                begin
                    // Emission walks the final run from either end.
                    a_next   = ascending_reg ? '0 : count_reg - CW'(1);
                    pos_next = count_reg;
                end
                else
                begin
                    ram_ctl.rd_en = 1'b1;
                    lo_next       = '0;
                    a_next        = '0;
                    b_next        = width_reg;
                    pos_next      = '0;
                end
            end
            ST_MERGE:
            begin
                ram_ctl.rd_en = 1'b1;
                ram_ctl.wr_a  = src_b_reg;
                ram_ctl.wr_b  = !src_b_reg;
                pos_next      = pos_inc;
                if (take_a)
                begin
                    a_next = a_reg + CW'(1);
                end
                else
                begin
                    b_next = b_reg + CW'(1);
                end
                if (pair_done)
                begin
                    if (pass_done)
                    begin
                        width_next = width_reg << 1;
                        src_b_next = !src_b_reg;
                    end
                    else
                    begin
                        // Go straight on with the next pair of runs.
                        lo_next = hi_e[CW-1:0];
                        a_next  = hi_e[CW-1:0];
                        b_next  = nb_e[CW-1:0];
                    end
                end
            end
            ST_EMIT:
            begin
                if (issue)
                begin
                    ram_ctl.rd_en  = 1'b1;
                    out_valid_next = 1'b1;
                    out_last_next  = pos_reg == CW'(1);
                    out_ovf_next   = dropped_reg;
                    pos_next       = pos_reg - CW'(1);
                    a_next         = ascending_reg ? a_reg + CW'(1) : a_reg - CW'(1);
                    if (pos_reg == CW'(1))
                    begin
                        count_next   = '0;
                        dropped_next = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Read addresses: the run heads for the next cycle, or the emit index.
    always_comb
    begin
        raddr0 = a_next[AW-1:0];
        raddr1 = b_next[AW-1:0];
        if (state_reg == ST_EMIT)
        begin
            raddr0 = a_reg[AW-1:0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_ovf_reg;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            ascending_reg <= 1'b1;
            width_reg     <= '0;
            lo_reg        <= '0;
            a_reg         <= '0;
            b_reg         <= '0;
            pos_reg       <= '0;
            src_b_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
            out_ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dropped_reg   <= dropped_next;
            ascending_reg <= ascending_next;
            width_reg     <= width_next;
            lo_reg        <= lo_next;
            a_reg         <= a_next;
            b_reg         <= b_next;
            pos_reg       <= pos_next;
            src_b_reg     <= src_b_next;
            out_valid_reg <= out_valid_next;
            out_last_reg  <= out_last_next;
            out_ovf_reg   <= out_ovf_next;
        end
    end

endmodule

>>> sv/bitonic_merge_sorter.sv
// Top level of the merge sorter: two element memories and the sequencer.
`timescale 1ns / 1ps

// Usage:
// Items enter on the s_ channel, one signed value per item; s_tlast marks the
// last item of a set and starts the sort. Up to CAPACITY values are stored;
// items beyond that are dropped and every result of that set carries
// m_tuser set. The sorted set leaves on the m_ channel, one item per value,
// with m_tlast on the final one, smallest first when the ascending register
// is 1 and largest first when it is 0. cfg_wr_en writes that register.
// The sort runs bottom-up merge passes between the two memories, ceil(log2 n)
// passes in all, one element written per cycle through the shared compare
// unit; ST_START begins the sort and ST_PASS_SETUP sets up emission. Results
// then leave at one per cycle while the receiver is ready, straight from the
// memory read register. s_tready is low from the last item until the final
// result is loaded into the read register; a new sort waits until that result
// has been taken. A stalled receiver holds the current result in the read
// register and pauses emission. Reset empties the set, clears the dropped
// flag and sets ascending order; memory contents are not cleared.

module bitonic_merge_sorter
    import bms_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [VALUE_W-1:0]   s_tdata,    // [31:0] value
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [VALUE_W-1:0]   m_tdata,    // [31:0] sorted_value
    output logic                 m_tlast,
    output logic                 m_tuser,    // [0] overflowed
    input  logic                 cfg_wr_en,
    input  logic                 cfg_wr_data
);

    localparam int AW = $clog2(CAPACITY);

    ram_ctl_t           ram_ctl;
    logic [AW-1:0]      waddr, raddr0, raddr1;
    logic [VALUE_W-1:0] wdata;
    logic [VALUE_W-1:0] a_rd0, a_rd1, b_rd0, b_rd1;
    logic [VALUE_W-1:0] head_a, head_b;

    // Source selection between the element and scratch memories.
    assign head_a  = ram_ctl.src_b ? b_rd0 : a_rd0;
    assign head_b  = ram_ctl.src_b ? b_rd1 : a_rd1;
    assign m_tdata = head_a;

    bms_ram #(
        .DEPTH (CAPACITY)
    ) u_elem_ram (
        .clk    (clk),
        .wr_en  (ram_ctl.wr_a),
        .waddr  (waddr),
        .wdata  (wdata),
        .rd_en  (ram_ctl.rd_en),
        .raddr0 (raddr0),
        .raddr1 (raddr1),
        .rdata0 (a_rd0),
        .rdata1 (a_rd1)
    );

    bms_ram #(
        .DEPTH (CAPACITY)
    ) u_scratch_ram (
        .clk    (clk),
        .wr_en  (ram_ctl.wr_b),
        .waddr  (waddr),
        .wdata  (wdata),
        .rd_en  (ram_ctl.rd_en),
        .raddr0 (raddr0),
        .raddr1 (raddr1),
        .rdata0 (b_rd0),
        .rdata1 (b_rd1)
    );

    bms_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_value     (s_tdata),
        .s_last      (s_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .head_a      (head_a),
        .head_b      (head_b),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser),
        .ram_ctl     (ram_ctl),
        .waddr       (waddr),
        .wdata       (wdata),
        .raddr0      (raddr0),
        .raddr1      (raddr1)
    );

endmodule

>>> sv/bms_checker.sv
// Port-level checks of the merge sorter and their binding to the top level.
`timescale 1ns / 1ps

module bms_checker
    import bms_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 s_tlast,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [VALUE_W-1:0]   m_tdata,
    input logic                 m_tlast
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its value.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result value changed while stalled");

    // The input is not ready right after the last item of a set is taken.
    a_in_closed: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input open right after the last item of a set");

    // Nothing follows the final result of a set in the next cycle.
    a_set_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tlast |=> !m_tvalid)
        else $error("result offered right after the end of a set");

endmodule

bind bitonic_merge_sorter bms_checker u_bms_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
